[rtl/srtp_pkg.sv]
// Shared constants, codes and record types of the sparse row table packer.
package srtp_pkg;

  localparam int SLOT_COUNT = 4096;
  localparam int COLUMNS    = 1024;
  localparam int MAX_PAIRS  = 256;

  localparam int SLOT_AW = $clog2(SLOT_COUNT);
  localparam int COL_W   = $clog2(COLUMNS);
  localparam int PAIR_AW = $clog2(MAX_PAIRS);
  localparam int CNT_W   = PAIR_AW + 1;
  localparam int BASE_AW = $clog2(SLOT_COUNT + COLUMNS);
  localparam int J_W     = BASE_AW + 1;
  localparam int VAL_W   = 15;
  localparam int BASE_W  = 13;
  localparam int CLR_LEN = SLOT_COUNT + COLUMNS;

  typedef enum logic [1:0] {
    KIND_PLACED = 2'd0,
    KIND_READ   = 2'd1,
    KIND_FULL   = 2'd2
  } kind_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_READ = 1'b1
  } op_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_RD_WAIT,
    S_BASE,
    S_BASE_WAIT,
    S_COL,
    S_COL_WAIT,
    S_SLOT_WAIT,
    S_WCOL,
    S_WWR,
    S_LF,
    S_LF_WAIT,
    S_OUT
  } state_t;

  typedef struct packed {
    logic             used;
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
  } slot_word_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [VAL_W-1:0] val;
  } pair_t;

endpackage

[rtl/srtp_ram.sv]
// Simple dual-port synchronous RAM, one write and one registered read per cycle.
module srtp_ram #(
  parameter int DEPTH = 4096,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/sparse_row_table_packer_unit.sv]
// Sparse row table packer: first-fit placement of sparse vectors into a slot table.
// Pair load without last: stored in S_IDLE. Slot read: S_RD_WAIT, S_OUT. Placement: S_BASE/
// S_BASE_WAIT per candidate base (S_BASE alone for skipped base zero), S_COL/S_COL_WAIT/
// S_SLOT_WAIT per pair probed, S_WCOL/S_WWR per pair written, S_LF/S_LF_WAIT per lowest_free probe.
// One request in flight; the next is taken once the result has been taken.
// Reset (sync, high) starts a clearing pass of all slot and base RAM entries; no requests then.
module sparse_row_table_packer_unit (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        op,
  input  logic [srtp_pkg::COL_W-1:0]  column,
  input  logic [srtp_pkg::VAL_W-1:0]  value,
  input  logic                        last,
  input  logic [srtp_pkg::SLOT_AW-1:0] address,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  kind,
  output logic signed [srtp_pkg::BASE_W-1:0] base,
  output logic [srtp_pkg::VAL_W-1:0]  slot_value,
  output logic [srtp_pkg::COL_W-1:0]  slot_column,
  output logic                        slot_used,
  output logic [srtp_pkg::SLOT_AW-1:0] highest
);

  localparam logic signed [srtp_pkg::J_W:0] TopLim =
    (srtp_pkg::J_W + 1)'(srtp_pkg::SLOT_COUNT);

  srtp_pkg::state_t state, state_next;

  // control and working registers
  logic [srtp_pkg::BASE_AW-1:0] clr_cnt;
  logic [srtp_pkg::CNT_W-1:0]   pend_cnt;
  logic [srtp_pkg::CNT_W-1:0]   npairs;
  logic [srtp_pkg::CNT_W-1:0]   k;
  logic [srtp_pkg::COL_W-1:0]   min_col, max_col;
  logic [srtp_pkg::SLOT_AW-1:0] lowest_free, highest_slot;
  logic signed [srtp_pkg::J_W-1:0] j;

  // RAM ports
  logic                           slot_we;
  logic [srtp_pkg::SLOT_AW-1:0]   slot_waddr, slot_raddr;
  srtp_pkg::slot_word_t           slot_wdata, slot_rd;
  logic                           base_we;
  logic [srtp_pkg::BASE_AW-1:0]   base_waddr, base_raddr;
  logic                           base_wdata, base_rd;
  logic                           pend_we;
  logic [srtp_pkg::PAIR_AW-1:0]   pend_waddr, pend_raddr;
  srtp_pkg::pair_t                pend_wdata, pend_rd;

  // datapath helpers
  logic                           accept, stores, last_pair, over;
  logic [srtp_pkg::CNT_W-1:0]     count_upd, k_inc;
  logic [srtp_pkg::COL_W-1:0]     min_upd, max_upd;
  logic signed [srtp_pkg::J_W-1:0] start, base_off, slot_sum;
  logic signed [srtp_pkg::J_W:0]  j_top;
  logic [srtp_pkg::BASE_AW-1:0]   base_idx;
  logic [srtp_pkg::SLOT_AW-1:0]   slot_probe;

  srtp_ram #(.DEPTH(srtp_pkg::SLOT_COUNT), .WIDTH($bits(srtp_pkg::slot_word_t))) u_slot_ram (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata),
    .raddr(slot_raddr), .rdata(slot_rd)
  );

  srtp_ram #(.DEPTH(srtp_pkg::CLR_LEN), .WIDTH(1)) u_base_ram (
    .clk(clk), .we(base_we), .waddr(base_waddr), .wdata(base_wdata),
    .raddr(base_raddr), .rdata(base_rd)
  );

  srtp_ram #(.DEPTH(srtp_pkg::MAX_PAIRS), .WIDTH($bits(srtp_pkg::pair_t))) u_pend_ram (
    .clk(clk), .we(pend_we), .waddr(pend_waddr), .wdata(pend_wdata),
    .raddr(pend_raddr), .rdata(pend_rd)
  );

  assign accept    = in_valid && in_ready;
  assign stores    = pend_cnt < srtp_pkg::CNT_W'(srtp_pkg::MAX_PAIRS);
  assign count_upd = pend_cnt + srtp_pkg::CNT_W'(stores);
  assign k_inc     = k + srtp_pkg::CNT_W'(1);
  assign last_pair = (k_inc == npairs);

  // running column range, including the pair being loaded now if it is stored
  always_comb begin
    min_upd = min_col;
    max_upd = max_col;
    if (pend_cnt == '0) begin
      min_upd = column;
      max_upd = column;
    end else if (stores) begin
      if (column < min_col) min_upd = column;
      if (column > max_col) max_upd = column;
    end
  end

  // first candidate: lowest_free minus the smallest column
  assign start = $signed(srtp_pkg::J_W'(lowest_free)) - $signed(srtp_pkg::J_W'(min_upd));
  assign j_top = $signed({j[srtp_pkg::J_W-1], j})
               + $signed((srtp_pkg::J_W + 1)'(max_col));
  assign over  = (j_top >= TopLim);

  assign base_off   = j + $signed(srtp_pkg::J_W'(srtp_pkg::COLUMNS));
  assign base_idx   = base_off[srtp_pkg::BASE_AW-1:0];
  assign slot_sum   = j + $signed(srtp_pkg::J_W'(pend_rd.col));
  assign slot_probe = slot_sum[srtp_pkg::SLOT_AW-1:0];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      srtp_pkg::S_CLEAR: begin
        if (clr_cnt == srtp_pkg::BASE_AW'(srtp_pkg::CLR_LEN - 1)) state_next = srtp_pkg::S_IDLE;
      end
      srtp_pkg::S_IDLE: begin
        if (accept) begin
          if (op == srtp_pkg::OP_READ) begin
            state_next = srtp_pkg::S_RD_WAIT;
          end else if (last) begin
            state_next = (count_upd == '0) ? srtp_pkg::S_OUT : srtp_pkg::S_BASE;
          end
        end
      end
      srtp_pkg::S_RD_WAIT:   state_next = srtp_pkg::S_OUT;
      srtp_pkg::S_BASE: begin
        if (over) state_next = srtp_pkg::S_OUT;
        else if (j != '0) state_next = srtp_pkg::S_BASE_WAIT;
      end
      srtp_pkg::S_BASE_WAIT: state_next = base_rd ? srtp_pkg::S_BASE : srtp_pkg::S_COL;
      srtp_pkg::S_COL:       state_next = srtp_pkg::S_COL_WAIT;
      srtp_pkg::S_COL_WAIT:  state_next = srtp_pkg::S_SLOT_WAIT;
      srtp_pkg::S_SLOT_WAIT: begin
        if (slot_rd.used) state_next = srtp_pkg::S_BASE;
        else if (last_pair) state_next = srtp_pkg::S_WCOL;
        else state_next = srtp_pkg::S_COL;
      end
      srtp_pkg::S_WCOL:      state_next = srtp_pkg::S_WWR;
      srtp_pkg::S_WWR:       state_next = last_pair ? srtp_pkg::S_LF : srtp_pkg::S_WCOL;
      srtp_pkg::S_LF:        state_next = srtp_pkg::S_LF_WAIT;
      srtp_pkg::S_LF_WAIT: begin
        if (lowest_free < srtp_pkg::SLOT_AW'(srtp_pkg::SLOT_COUNT - 1) && slot_rd.used) begin
          state_next = srtp_pkg::S_LF;
        end else begin
          state_next = srtp_pkg::S_OUT;
        end
      end
      srtp_pkg::S_OUT:       if (out_ready) state_next = srtp_pkg::S_IDLE;
      default:               state_next = srtp_pkg::S_CLEAR;
    endcase
  end

  // RAM controls and handshake outputs
  always_comb begin
    in_ready   = 1'b0;
    out_valid  = 1'b0;
    slot_we    = 1'b0;
    slot_waddr = slot_probe;
    slot_wdata = '{used: 1'b1, col: pend_rd.col, val: pend_rd.val};
    slot_raddr = lowest_free;
    base_we    = 1'b0;
    base_waddr = base_idx;
    base_wdata = 1'b1;
    base_raddr = base_idx;
    pend_we    = 1'b0;
    pend_waddr = pend_cnt[srtp_pkg::PAIR_AW-1:0];
    pend_wdata = '{col: column, val: value};
    pend_raddr = k[srtp_pkg::PAIR_AW-1:0];
    case (state)
      srtp_pkg::S_CLEAR: begin
        slot_we    = clr_cnt < srtp_pkg::BASE_AW'(srtp_pkg::SLOT_COUNT);
        slot_waddr = clr_cnt[srtp_pkg::SLOT_AW-1:0];
        slot_wdata = '0;
        base_we    = 1'b1;
        base_waddr = clr_cnt;
        base_wdata = 1'b0;
      end
      srtp_pkg::S_IDLE: begin
        in_ready   = 1'b1;
        slot_raddr = address;
        pend_we    = in_valid && (op == srtp_pkg::OP_LOAD) && stores;
      end
      srtp_pkg::S_COL_WAIT:  slot_raddr = slot_probe;
      srtp_pkg::S_WWR: begin
        slot_we = 1'b1;
        base_we = last_pair;
      end
      srtp_pkg::S_OUT:       out_valid = 1'b1;
      default: ;
    endcase
  end

  // registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= srtp_pkg::S_CLEAR;
      clr_cnt      <= '0;
      pend_cnt     <= '0;
      lowest_free  <= '0;
      highest_slot <= '0;
    end else begin
      state <= state_next;
      case (state)
        srtp_pkg::S_CLEAR: clr_cnt <= clr_cnt + srtp_pkg::BASE_AW'(1);
        srtp_pkg::S_IDLE: begin
          if (accept && op == srtp_pkg::OP_LOAD) begin
            if (stores) begin
              min_col <= min_upd;
              max_col <= max_upd;
            end
            if (last) begin
              pend_cnt    <= '0;
              npairs      <= count_upd;
              j           <= start;
              k           <= '0;
              kind        <= srtp_pkg::KIND_FULL;
              base        <= '0;
              slot_value  <= '0;
              slot_column <= '0;
              slot_used   <= 1'b0;
              highest     <= highest_slot;
            end else begin
              pend_cnt    <= count_upd;
            end
          end
        end
        srtp_pkg::S_RD_WAIT: begin
          kind        <= srtp_pkg::KIND_READ;
          base        <= '0;
          slot_value  <= slot_rd.used ? slot_rd.val : '0;
          slot_column <= slot_rd.used ? slot_rd.col : '0;
          slot_used   <= slot_rd.used;
          highest     <= highest_slot;
        end
        srtp_pkg::S_BASE: begin
          if (!over && j == '0) j <= j + srtp_pkg::J_W'(1);
        end
        srtp_pkg::S_BASE_WAIT: begin
          if (base_rd) j <= j + srtp_pkg::J_W'(1);
          else k <= '0;
        end
        srtp_pkg::S_SLOT_WAIT: begin
          if (slot_rd.used) j <= j + srtp_pkg::J_W'(1);
          else k <= last_pair ? '0 : k_inc;
        end
        srtp_pkg::S_WWR: begin
          if (slot_probe > highest_slot) highest_slot <= slot_probe;
          k <= k_inc;
        end
        srtp_pkg::S_LF_WAIT: begin
          if (lowest_free < srtp_pkg::SLOT_AW'(srtp_pkg::SLOT_COUNT - 1) && slot_rd.used) begin
            lowest_free <= lowest_free + srtp_pkg::SLOT_AW'(1);
          end else begin
            kind    <= srtp_pkg::KIND_PLACED;
            base    <= j[srtp_pkg::BASE_W-1:0];
            highest <= highest_slot;
          end
        end
        default: ;
      endcase
    end
  end

  // one request at a time: never ready while a result waits
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("request taken while result pending");

  // a read result carries base zero
  a_read_base: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == srtp_pkg::KIND_READ) |-> (base == '0))
    else $error("read result with nonzero base");

  // a full-table answer reports no slot
  a_full_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == srtp_pkg::KIND_FULL) |-> (!slot_used && base == '0))
    else $error("table full result carries slot data");

  // a placed vector never reports base zero
  a_base_nonzero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && kind == srtp_pkg::KIND_PLACED) |-> (base != '0))
    else $error("vector placed at base zero");

endmodule
